### hdl/frsqrt_pkg.sv
`default_nettype none
package frsqrt_pkg;

  localparam logic [31:0] MAGIC          = 32'h5f375a86;
  localparam logic [31:0] ONE_HALF       = 32'h3F000000;
  localparam logic [31:0] THREE_HALVES   = 32'h3FC00000;
  localparam logic [31:0] QNAN           = 32'h7FC00000;
  localparam logic [31:0] SIGN_MASK      = 32'h80000000;
  localparam logic [30:0] INF_MAG        = 31'h7F800000;

  // Pipeline depths of the float units
  localparam int MUL_DEPTH  = 3;
  localparam int ADD_DEPTH  = 4;

  // Intermediate result between arithmetic and rounding:
  // value = sig * 2^exp, or a fixed pattern when spec is set.
  typedef struct packed {
    logic                spec;
    logic [31:0]         spec_val;
    logic                sign;
    logic signed [11:0]  exp;
    logic [63:0]         sig;
  } op_t;

  function automatic logic is_nan(input logic [31:0] a);
    return a[30:0] > INF_MAG;
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return a[30:0] == INF_MAG;
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] unpack_sig(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
  endfunction

  function automatic logic signed [11:0] unpack_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? -12'sd149 : ($signed({4'd0, a[30:23]}) - 12'sd150);
  endfunction

  // Shift the significand up to bit 63; exp becomes the biased exponent.
  function automatic op_t normalize(input op_t op);
    op_t        r;
    logic [6:0] lz;
    r  = op;
    lz = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (op.sig[i]) lz = 7'(63 - i);
    end
    if (!op.spec) begin
      r.sig = op.sig << lz;
      r.exp = op.exp + 12'sd190 - $signed({5'd0, lz});
    end
    return r;
  endfunction

  // Round to nearest even and pack a normalized operand.
  function automatic logic [31:0] round_pack(input op_t op);
    logic signed [11:0] b;
    logic signed [11:0] d;
    logic [6:0]         s;
    logic [63:0]        mant;
    logic [63:0]        mask;
    logic [63:0]        rem;
    logic [63:0]        half_v;
    logic [31:0]        r;
    b = op.exp;
    d = (b < 12'sd1) ? (12'sd41 - b) : 12'sd40;
    s = 7'd0;
    mant = 64'd0;
    mask = 64'd0;
    rem = 64'd0;
    half_v = 64'd0;
    if (op.spec) begin
      r = op.spec_val;
    end else if (d > 12'sd64) begin
      r = {op.sign, 31'd0};
    end else begin
      s      = d[6:0];
      mant   = op.sig >> s;
      mask   = (64'd1 << s) - 64'd1;
      rem    = op.sig & mask;
      half_v = 64'd1 << (s - 7'd1);
      if (rem > half_v || (rem == half_v && mant[0])) mant = mant + 64'd1;
      if (b < 12'sd1) begin
        // a carry into the exponent field is the correct result
        r = {op.sign, mant[30:0]};
      end else begin
        if (mant[24]) begin
          mant = mant >> 1;
          b    = b + 12'sd1;
        end
        if (b >= 12'sd255) r = {op.sign, INF_MAG};
        else r = {op.sign, b[7:0], mant[22:0]};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/frsqrt_mul.sv
`default_nettype none
module frsqrt_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        vld_in,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             vld_out,
  output logic [31:0]      y
);

  frsqrt_pkg::op_t prod;
  frsqrt_pkg::op_t norm;
  frsqrt_pkg::op_t prod_next;
  logic            vld1;
  logic            vld2;
  logic            sign;
  logic [47:0]     sig_prod;

  always_comb begin
    sign = a[31] ^ b[31];
    sig_prod = frsqrt_pkg::unpack_sig(a) * frsqrt_pkg::unpack_sig(b);
    prod_next = '0;
    prod_next.sign = sign;
    if (frsqrt_pkg::is_nan(a) || frsqrt_pkg::is_nan(b)) begin
      prod_next.spec = 1'b1;
      prod_next.spec_val = frsqrt_pkg::QNAN;
    end else if (frsqrt_pkg::is_inf(a) || frsqrt_pkg::is_inf(b)) begin
      prod_next.spec = 1'b1;
      prod_next.spec_val = (frsqrt_pkg::is_zero(a) || frsqrt_pkg::is_zero(b)) ?
                           frsqrt_pkg::QNAN : {sign, frsqrt_pkg::INF_MAG};
    end else if (frsqrt_pkg::is_zero(a) || frsqrt_pkg::is_zero(b)) begin
      prod_next.spec = 1'b1;
      prod_next.spec_val = {sign, 31'd0};
    end else begin
      prod_next.exp = frsqrt_pkg::unpack_exp(a) + frsqrt_pkg::unpack_exp(b);
      prod_next.sig = {16'd0, sig_prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld2    <= vld1;
      vld_out <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      norm <= frsqrt_pkg::normalize(prod);
      y    <= frsqrt_pkg::round_pack(norm);
    end
  end

endmodule
`default_nettype wire

### hdl/frsqrt_add.sv
`default_nettype none
module frsqrt_add (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        vld_in,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             vld_out,
  output logic [31:0]      y
);

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sgn_a;
    logic               sgn_b;
    logic signed [11:0] exp;
    logic [63:0]        sa;
    logic [63:0]        sb;
  } align_t;

  align_t             al;
  align_t             al_next;
  frsqrt_pkg::op_t    sum;
  frsqrt_pkg::op_t    sum_next;
  frsqrt_pkg::op_t    norm;
  logic               vld1;
  logic               vld2;
  logic               vld3;
  logic [63:0]        xa;
  logic [63:0]        xb;
  logic signed [11:0] ea;
  logic signed [11:0] eb;
  logic signed [11:0] d;
  logic [63:0]        lost_mask;

  // Stage 1: specials, swap so the larger exponent leads, align with sticky
  always_comb begin
    al_next = '0;
    xa = {26'd0, frsqrt_pkg::unpack_sig(a), 14'd0} << 24;
    xb = {26'd0, frsqrt_pkg::unpack_sig(b), 14'd0} << 24;
    ea = frsqrt_pkg::unpack_exp(a);
    eb = frsqrt_pkg::unpack_exp(b);
    d  = 12'sd0;
    lost_mask = 64'd0;
    al_next.sgn_a = a[31];
    al_next.sgn_b = b[31];
    if (frsqrt_pkg::is_nan(a) || frsqrt_pkg::is_nan(b)) begin
      al_next.spec = 1'b1;
      al_next.spec_val = frsqrt_pkg::QNAN;
    end else if (frsqrt_pkg::is_inf(a)) begin
      al_next.spec = 1'b1;
      al_next.spec_val = (frsqrt_pkg::is_inf(b) && a[31] != b[31]) ? frsqrt_pkg::QNAN : a;
    end else if (frsqrt_pkg::is_inf(b)) begin
      al_next.spec = 1'b1;
      al_next.spec_val = b;
    end else if (frsqrt_pkg::is_zero(a) && frsqrt_pkg::is_zero(b)) begin
      al_next.spec = 1'b1;
      al_next.spec_val = {a[31] & b[31], 31'd0};
    end else if (frsqrt_pkg::is_zero(a)) begin
      al_next.spec = 1'b1;
      al_next.spec_val = b;
    end else if (frsqrt_pkg::is_zero(b)) begin
      al_next.spec = 1'b1;
      al_next.spec_val = a;
    end else begin
      if (ea < eb) begin
        al_next.sgn_a = b[31];
        al_next.sgn_b = a[31];
        al_next.sa = xb;
        al_next.sb = xa;
        al_next.exp = eb;
        d = eb - ea;
      end else begin
        al_next.sa = xa;
        al_next.sb = xb;
        al_next.exp = ea;
        d = ea - eb;
      end
      if (d >= 12'sd63) begin
        al_next.sb = 64'd1;
      end else if (d > 12'sd0) begin
        lost_mask = (64'd1 << d[5:0]) - 64'd1;
        al_next.sb = (al_next.sb >> d[5:0]) | {63'd0, |(al_next.sb & lost_mask)};
      end
    end
  end

  // Stage 2: add or subtract magnitudes
  always_comb begin
    sum_next = '0;
    sum_next.spec = al.spec;
    sum_next.spec_val = al.spec_val;
    sum_next.exp = al.exp - 12'sd38;
    sum_next.sign = al.sgn_a;
    if (!al.spec) begin
      if (al.sgn_a == al.sgn_b) begin
        sum_next.sig = al.sa + al.sb;
      end else if (al.sa == al.sb) begin
        sum_next.spec = 1'b1;
        sum_next.spec_val = 32'd0;
      end else if (al.sa > al.sb) begin
        sum_next.sig = al.sa - al.sb;
      end else begin
        sum_next.sign = al.sgn_b;
        sum_next.sig = al.sb - al.sa;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld2    <= vld1;
      vld3    <= vld2;
      vld_out <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al   <= al_next;
      sum  <= sum_next;
      norm <= frsqrt_pkg::normalize(sum);
      y    <= frsqrt_pkg::round_pack(norm);
    end
  end

endmodule
`default_nettype wire

### hdl/frsqrt_newton.sv
`default_nettype none
module frsqrt_newton (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        vld_in,
  input  wire logic [31:0] guess_in,
  input  wire logic [31:0] half_in,
  output logic             vld_out,
  output logic [31:0]      guess_out,
  output logic [31:0]      half_out
);

  localparam int D1 = frsqrt_pkg::MUL_DEPTH;
  localparam int D2 = frsqrt_pkg::MUL_DEPTH;
  localparam int D3 = frsqrt_pkg::ADD_DEPTH;
  localparam int D4 = frsqrt_pkg::MUL_DEPTH;

  logic [31:0] g1 [D1];
  logic [31:0] g2 [D2];
  logic [31:0] g3 [D3];
  logic [31:0] h1 [D1];
  logic [31:0] h2 [D2];
  logic [31:0] h3 [D3];
  logic [31:0] h4 [D4];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic        v1;
  logic        v2;
  logic        v3;

  // Hold the guess and half alongside the float units
  always_ff @(posedge clk) begin
    if (en) begin
      g1[0] <= guess_in;
      h1[0] <= half_in;
      for (int i = 1; i < D1; i++) begin
        g1[i] <= g1[i-1];
        h1[i] <= h1[i-1];
      end
      g2[0] <= g1[D1-1];
      h2[0] <= h1[D1-1];
      for (int i = 1; i < D2; i++) begin
        g2[i] <= g2[i-1];
        h2[i] <= h2[i-1];
      end
      g3[0] <= g2[D2-1];
      h3[0] <= h2[D2-1];
      for (int i = 1; i < D3; i++) begin
        g3[i] <= g3[i-1];
        h3[i] <= h3[i-1];
      end
      h4[0] <= h3[D3-1];
      for (int i = 1; i < D4; i++) h4[i] <= h4[i-1];
    end
  end

  frsqrt_mul u_mul_hy (
    .clk(clk), .rst(rst), .en(en), .vld_in(vld_in),
    .a(half_in), .b(guess_in), .vld_out(v1), .y(t1)
  );

  frsqrt_mul u_mul_hyy (
    .clk(clk), .rst(rst), .en(en), .vld_in(v1),
    .a(t1), .b(g1[D1-1]), .vld_out(v2), .y(t2)
  );

  frsqrt_add u_sub (
    .clk(clk), .rst(rst), .en(en), .vld_in(v2),
    .a(frsqrt_pkg::THREE_HALVES), .b(t2 ^ frsqrt_pkg::SIGN_MASK),
    .vld_out(v3), .y(t3)
  );

  frsqrt_mul u_mul_y (
    .clk(clk), .rst(rst), .en(en), .vld_in(v3),
    .a(g3[D3-1]), .b(t3), .vld_out(vld_out), .y(guess_out)
  );

  assign half_out = h4[D4-1];

endmodule
`default_nettype wire

### hdl/fast_reciprocal_sqrt_unit.sv
`default_nettype none
// Approximate 1/sqrt(x) on binary32 bit patterns: magic-constant guess
// followed by two Newton steps, each float operation rounded to nearest even.
// Input channel: in_valid / in_stall with value_bits. A transfer happens on
// a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with result_bits, same rule.
// Throughput: one item per cycle while the receiver does not stall.
// The datapath is a chain of nine float units (one multiply, then per
// Newton step two multiplies of 3 stages, one add of 4 stages and one
// multiply of 3 stages).
// Up to one item per pipeline stage can be in flight.
// Reset clears all valid bits; no result is presented until new input.
// When a result waits with out_stall high the whole pipeline holds and
// in_stall goes high; nothing is dropped or repeated.
// Negative, zero, infinite and NaN inputs go through the same path.
module fast_reciprocal_sqrt_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] value_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result_bits
);

  localparam int HD = frsqrt_pkg::MUL_DEPTH;

  logic        en;
  logic        vh;
  logic [31:0] half;
  logic [31:0] gd [HD];
  logic        v1;
  logic [31:0] g1;
  logic [31:0] h1;
  logic [31:0] h2;
  logic [31:0] guess0;

  // advance unless a finished result is held back
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign guess0   = frsqrt_pkg::MAGIC - {value_bits[31], value_bits[31:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      gd[0] <= guess0;
      for (int i = 1; i < HD; i++) gd[i] <= gd[i-1];
    end
  end

  frsqrt_mul u_half (
    .clk(clk), .rst(rst), .en(en), .vld_in(in_valid),
    .a(value_bits), .b(frsqrt_pkg::ONE_HALF), .vld_out(vh), .y(half)
  );

  frsqrt_newton u_step1 (
    .clk(clk), .rst(rst), .en(en), .vld_in(vh),
    .guess_in(gd[HD-1]), .half_in(half),
    .vld_out(v1), .guess_out(g1), .half_out(h1)
  );

  frsqrt_newton u_step2 (
    .clk(clk), .rst(rst), .en(en), .vld_in(v1),
    .guess_in(g1), .half_in(h1),
    .vld_out(out_valid), .guess_out(result_bits), .half_out(h2)
  );

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LATENCY     = 29;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 120;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] value_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result_bits;

  fast_reciprocal_sqrt_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value_bits(value_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_bits(result_bits)
  );

  logic [31:0] pending_values[$];
  logic [31:0] expected_rsqrt[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          cycle = 0;
  bit          sender_pause = 0;
  int          pause_at = 600;

  // Round sig * 2^e to binary32.
  function automatic logic [31:0] fp_round(logic sgn, int e, logic [63:0] sig);
    int          biased;
    int          s;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] hv;
    while (!sig[63]) begin
      sig = sig << 1;
      e = e - 1;
    end
    biased = e + 63 + 127;
    s = (biased < 1) ? 40 + (1 - biased) : 40;
    if (s >= 65) return {sgn, 31'd0};
    if (s == 64) begin
      mant = 64'd0;
      rem = sig;
    end else begin
      mant = sig >> s;
      rem = sig & ((64'd1 << s) - 64'd1);
    end
    hv = 64'd1 << (s - 1);
    if (rem > hv || (rem == hv && mant[0])) mant = mant + 64'd1;
    if (biased < 1) return {sgn, mant[30:0]};
    if (mant == (64'd1 << 24)) begin
      mant = mant >> 1;
      biased = biased + 1;
    end
    if (biased >= 255) return {sgn, frsqrt_pkg::INF_MAG};
    return {sgn, biased[7:0], mant[22:0]};
  endfunction

  function automatic logic f_nan(logic [31:0] a);
    return a[30:0] > frsqrt_pkg::INF_MAG;
  endfunction

  function automatic logic f_inf(logic [31:0] a);
    return a[30:0] == frsqrt_pkg::INF_MAG;
  endfunction

  function automatic logic f_zero(logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [63:0] f_sig(logic [31:0] a);
    return (a[30:23] == 8'd0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
  endfunction

  function automatic int f_exp(logic [31:0] a);
    return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return frsqrt_pkg::QNAN;
    if (f_inf(a) || f_inf(b)) begin
      if (f_zero(a) || f_zero(b)) return frsqrt_pkg::QNAN;
      return {sgn, frsqrt_pkg::INF_MAG};
    end
    if (f_zero(a) || f_zero(b)) return {sgn, 31'd0};
    return fp_round(sgn, f_exp(a) + f_exp(b), f_sig(a) * f_sig(b));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic        sa_sgn, sb_sgn, ts;
    logic [63:0] sa, sb, tsig;
    int          ea, eb, te, d;
    sa_sgn = a[31];
    sb_sgn = b[31];
    if (f_nan(a) || f_nan(b)) return frsqrt_pkg::QNAN;
    if (f_inf(a)) begin
      if (f_inf(b) && sa_sgn != sb_sgn) return frsqrt_pkg::QNAN;
      return a;
    end
    if (f_inf(b)) return b;
    if (f_zero(a) && f_zero(b)) return {sa_sgn & sb_sgn, 31'd0};
    if (f_zero(a)) return b;
    if (f_zero(b)) return a;
    sa = f_sig(a) << 38;
    sb = f_sig(b) << 38;
    ea = f_exp(a);
    eb = f_exp(b);
    if (ea < eb) begin
      tsig = sa; te = ea; ts = sa_sgn;
      sa = sb; ea = eb; sa_sgn = sb_sgn;
      sb = tsig; eb = te; sb_sgn = ts;
    end
    d = ea - eb;
    if (d >= 63) sb = 64'd1;
    else if (d > 0) sb = (sb >> d) | 64'(|(sb & ((64'd1 << d) - 64'd1)));
    if (sa_sgn == sb_sgn) return fp_round(sa_sgn, ea - 38, sa + sb);
    if (sa == sb) return 32'd0;
    if (sa > sb) return fp_round(sa_sgn, ea - 38, sa - sb);
    return fp_round(sb_sgn, ea - 38, sb - sa);
  endfunction

  function automatic logic [31:0] newton_refine(logic [31:0] y, logic [31:0] hx);
    logic [31:0] t;
    t = fp_mul(fp_mul(hx, y), y);
    t = fp_add(frsqrt_pkg::THREE_HALVES, t ^ frsqrt_pkg::SIGN_MASK);
    return fp_mul(y, t);
  endfunction

  function automatic logic [31:0] rsqrt_approx(logic [31:0] v);
    logic [31:0] hx, y;
    hx = fp_mul(v, frsqrt_pkg::ONE_HALF);
    y = frsqrt_pkg::MAGIC - {v[31], v[31:1]};
    y = newton_refine(y, hx);
    return newton_refine(y, hx);
  endfunction

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'hFF;
      2, 3, 4, 5: v[30:23] = 8'($urandom_range(100, 160));
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) v[31] = 1'b0;
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h007FFFFF,
                 32'h00800000, 32'h3F800000, 32'h40800000, 32'h3E800000,
                 32'h7F7FFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                 32'h7F800001, 32'hFFFFFFFF, 32'hBF800000, 32'h80000001,
                 32'h5F375A86, 32'hBEEF1234, 32'h3F000000, 32'h40490FDB,
                 32'h00000002, 32'hAAAAAAAA, 32'h55555555};
    foreach (directed[i]) pending_values.push_back(directed[i]);
    for (int i = 0; i < 1030; i++) pending_values.push_back(random_float());
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: hold the payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      value_bits <= 32'd0;
    end else begin
      if (in_valid && !in_stall) expected_rsqrt.push_back(rsqrt_approx(value_bits));
      if (!in_valid || !in_stall) begin
        if (in_valid && !in_stall && pending_values.size() == pause_at) begin
          sender_pause <= 1'b1;
          in_valid <= 1'b0;
        end else if (sender_pause) begin
          in_valid <= 1'b0;
          if (expected_rsqrt.size() == 0 && !out_valid) sender_pause <= 1'b0;
        end else if (pending_values.size() != 0 &&
                     ((cycle >= 1000 && cycle < 1300) || $urandom_range(0, 99) >= 25)) begin
          in_valid <= 1'b1;
          value_bits <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
          value_bits <= $urandom;
        end
      end
    end
  end

  // Monitor and receiver stall; a long hold-off early freezes the pipeline with items in flight.
  always @(posedge clk) begin
    logic [31:0] want;
    cycle <= cycle + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsqrt.size() == 0) begin
          $display("%0t: unexpected transfer, actual %h", $time, result_bits);
          mismatches++;
        end else begin
          want = expected_rsqrt.pop_front();
          if (want !== result_bits) begin
            $display("%0t: result_bits expected %h actual %h", $time, want, result_bits);
            mismatches++;
          end
        end
      end
      if (cycle >= 100 && cycle < 100 + HOLD_CYCLES) out_stall <= 1'b1;
      else if (cycle < 4000 && cycle >= 1000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 25);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_valid = 1'b0;
    value_bits = 32'd0;
    out_stall = 1'b0;
    @(negedge rst);
    fork
      begin
        wait (pending_values.size() == 0 && !in_valid && expected_rsqrt.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0 && expected_rsqrt.size() == 0) begin
          $display("No mismatches found");
        end else begin
          $display("Mismatches found");
        end
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout");
        $display("Mismatches found");
      end
    join_any
    $finish;
  end
endmodule
`default_nettype wire

### files.f
hdl/frsqrt_pkg.sv
hdl/frsqrt_mul.sv
hdl/frsqrt_add.sv
hdl/frsqrt_newton.sv
hdl/fast_reciprocal_sqrt_unit.sv
test/tb.sv
